// ===== hw/rtl/smp_pkg.sv =====
// shared types and constants for the snapshot marker participant
`timescale 1ns / 1ps
`default_nettype none
package smp_pkg;

   localparam int MAX_PEERS       = 16;
   localparam int PEER_W          = 4;
   localparam int NUM_W           = 5;
   localparam int WORD_W          = 64;
   localparam int LEN_W           = 16;
   localparam int SIZE_W          = 24;
   localparam int RECORD_OVERHEAD = 48;

   localparam logic [WORD_W-1:0] ALL_ONES = '1;

   localparam logic [1:0] CSR_PEER_COUNT   = 2'd0;
   localparam logic [1:0] CSR_RECORD_LIMIT = 2'd1;

   typedef enum logic [2:0] {
      OP_INIT = 3'd0,
      OP_SEND = 3'd1,
      OP_RECV = 3'd2,
      OP_MARK = 3'd3,
      OP_TAKE = 3'd4,
      OP_NONE = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      KIND_TX_MARKER = 3'd0,
      KIND_TX_DATA   = 3'd1,
      KIND_DELIVER   = 3'd2,
      KIND_RECORD    = 3'd3,
      KIND_ENTRY     = 3'd4,
      KIND_STATUS    = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      ERR_OK          = 4'd0,
      ERR_FAILED      = 4'd1,
      ERR_UNKNOWN     = 4'd2,
      ERR_STALE       = 4'd3,
      ERR_STATE_LIMIT = 4'd4,
      ERR_SEND_OVF    = 4'd5,
      ERR_NON_FIFO    = 4'd6,
      ERR_REC_LIMIT   = 4'd7,
      ERR_BAD_MARKER  = 4'd8,
      ERR_FRONTIER    = 4'd9,
      ERR_DUP_MARKER  = 4'd10,
      ERR_INCOMPLETE  = 4'd11
   } err_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EXEC,
      BK_LOOP,
      BK_ONE1,
      BK_ONE2,
      BK_STATUS
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [PEER_W-1:0]   peer;
      logic [WORD_W-1:0]   epoch;
      logic [WORD_W-1:0]   seq;
      logic [LEN_W-1:0]    len;
      logic [SIZE_W-1:0]   cap;
   } req_item_type;

   typedef struct packed {
      kind_type            kind;
      logic [PEER_W-1:0]   peer;
      logic [WORD_W-1:0]   seq;
      logic [WORD_W-1:0]   rcv;
      logic [WORD_W-1:0]   mseq;
      logic [WORD_W-1:0]   epoch;
      logic [LEN_W-1:0]    len;
      logic                completed;
      err_type             err;
      logic                last;
   } rsp_item_type;

   typedef struct packed {
      logic [NUM_W-1:0]    peer_count;
      logic [SIZE_W-1:0]   record_limit;
   } cfg_type;

endpackage
`default_nettype wire

// ===== hw/rtl/smp_front.sv =====
// front end: request queue with opcode classification
`timescale 1ns / 1ps
`default_nettype none
module smp_front
   import smp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic [2:0]         req_type,
   input  wire logic [PEER_W-1:0]  req_peer,
   input  wire logic [WORD_W-1:0]  req_epoch,
   input  wire logic [WORD_W-1:0]  req_sequence_req,
   input  wire logic [LEN_W-1:0]   req_payload_length,
   input  wire logic [SIZE_W-1:0]  req_captured_size,
   output logic                    q_valid,
   output req_item_type            q_item,
   input  wire logic               q_pop
);

   req_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   req_item_type item;
   logic         do_push, do_pop;

   // opcode decode
   always_comb begin
      item.peer  = req_peer;
      item.epoch = req_epoch;
      item.seq   = req_sequence_req;
      item.len   = req_payload_length;
      item.cap   = req_captured_size;
      unique case (req_type)
         OP_INIT: item.op = OP_INIT;
         OP_SEND: item.op = OP_SEND;
         OP_RECV: item.op = OP_RECV;
         OP_MARK: item.op = OP_MARK;
         OP_TAKE: item.op = OP_TAKE;
         default: item.op = OP_NONE;
      endcase
   end

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/smp_rsp_fifo.sv =====
// result queue in front of the output channel
`timescale 1ns / 1ps
`default_nettype none
module smp_rsp_fifo
   import smp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  wr_en,
   input  wire rsp_item_type wr_item,
   output logic       wr_full,
   input  wire logic  pop,
   output logic       empty,
   output rsp_item_type rd_item
);

   rsp_item_type entry_ff [4];
   logic [1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [2:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign wr_full = (count_ff == 3'd4);
   assign empty   = (count_ff == 3'd0);
   assign rd_item = entry_ff[rd_ptr_ff];
   assign do_push = wr_en && !wr_full;
   assign do_pop  = pop && !empty;
   assign count_in = count_ff + {2'b0, do_push} - {2'b0, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/smp_back.sv =====
// back end: snapshot state, event execution and result sequencing
`timescale 1ns / 1ps
`default_nettype none
module smp_back
   import smp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  q_valid,
   input  wire req_item_type q_item,
   output logic       q_pop,
   input  wire cfg_type cfg,
   output logic       rsp_write,
   output rsp_item_type rsp_item,
   input  wire logic  rsp_full
);

   back_state_type state_ff, state_in;
   req_item_type   cur_ff;
   err_type        err_ff, err_in;
   logic           loop_entry_ff, loop_entry_in;
   logic [NUM_W-1:0] idx_ff, idx_in;
   rsp_item_type   one1_ff, one2_ff, one1_in, one2_in;
   logic           loop_vld_in, one1_vld_in, one2_vld_in;

   logic [WORD_W-1:0] sent_ff      [MAX_PEERS];
   logic [WORD_W-1:0] recv_ff      [MAX_PEERS];
   logic [WORD_W-1:0] snap_sent_ff [MAX_PEERS];
   logic [WORD_W-1:0] snap_recv_ff [MAX_PEERS];
   logic [WORD_W-1:0] mseq_ff      [MAX_PEERS];
   logic [MAX_PEERS-1:0] marked_ff, marked_in;
   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [WORD_W-1:0] cur_epoch_ff, cur_epoch_in;
   logic [WORD_W-1:0] fin_epoch_ff, fin_epoch_in;
   logic [SIZE_W-1:0] recorded_ff, recorded_in;
   logic              failed_ff, failed_in;

   logic [NUM_W-1:0]     n_use;
   logic [MAX_PEERS-1:0] in_use, p_bit, marked_new;
   logic                 p_known;
   logic [WORD_W-1:0]    sent_p, recv_p;
   err_type              st_err;
   logic [SIZE_W-1:0]    avail;
   logic [SIZE_W:0]      need;
   logic                 rec_bad;
   logic                 exec, do_start, do_send, do_deliver, do_mark;
   logic [PEER_W-1:0]    li;

   // peers in use, clamped
   assign n_use = (cfg.peer_count > NUM_W'(MAX_PEERS)) ? NUM_W'(MAX_PEERS) : cfg.peer_count;

   always_comb begin
      for (int i = 0; i < MAX_PEERS; i++) begin
         in_use[i] = (NUM_W'(i) < n_use);
      end
   end

   assign p_known = ({1'b0, cur_ff.peer} < n_use);
   assign p_bit   = MAX_PEERS'(1) << cur_ff.peer;
   assign sent_p  = sent_ff[cur_ff.peer];
   assign recv_p  = recv_ff[cur_ff.peer];

   assign st_err = ((cur_ff.epoch <= fin_epoch_ff) || active_ff || done_ff) ? ERR_STALE :
                   (cur_ff.cap > cfg.record_limit) ? ERR_STATE_LIMIT : ERR_OK;

   // record budget check
   assign avail   = cfg.record_limit - recorded_ff;
   assign need    = (SIZE_W+1)'(cur_ff.len) + (SIZE_W+1)'(RECORD_OVERHEAD);
   assign rec_bad = (recorded_ff > cfg.record_limit) || (need > {1'b0, avail});

   assign exec = (state_ff == BK_EXEC);

   // event execution
   always_comb begin
      err_in        = ERR_OK;
      do_start      = 1'b0;
      do_send       = 1'b0;
      do_deliver    = 1'b0;
      do_mark       = 1'b0;
      loop_vld_in   = 1'b0;
      loop_entry_in = 1'b0;
      one1_vld_in   = 1'b0;
      one2_vld_in   = 1'b0;
      marked_in     = marked_ff;
      active_in     = active_ff;
      done_in       = done_ff;
      cur_epoch_in  = cur_epoch_ff;
      fin_epoch_in  = fin_epoch_ff;
      recorded_in   = recorded_ff;
      failed_in     = failed_ff;
      marked_new    = marked_ff | p_bit;
      one1_in       = '0;
      one1_in.kind  = KIND_RECORD;
      one1_in.peer  = cur_ff.peer;
      one1_in.seq   = cur_ff.seq;
      one1_in.len   = cur_ff.len;
      one1_in.err   = ERR_OK;
      one2_in       = '0;
      one2_in.kind  = KIND_DELIVER;
      one2_in.peer  = cur_ff.peer;
      one2_in.seq   = cur_ff.seq;
      one2_in.len   = cur_ff.len;
      one2_in.err   = ERR_OK;

      if (exec) begin
         priority if (cur_ff.op == OP_NONE) begin
            err_in = ERR_OK;
         end else if (failed_ff) begin
            err_in = ERR_FAILED;
         end else if (cur_ff.op == OP_INIT) begin
            err_in = st_err;
            if (st_err == ERR_OK) begin
               do_start    = 1'b1;
               loop_vld_in = 1'b1;
               if (n_use == '0) begin
                  done_in      = 1'b1;
                  fin_epoch_in = cur_ff.epoch;
               end
            end
         end else if (cur_ff.op == OP_TAKE) begin
            if (!done_ff) begin
               err_in = ERR_INCOMPLETE;
            end else begin
               loop_vld_in   = 1'b1;
               loop_entry_in = 1'b1;
               done_in       = 1'b0;
            end
         end else if (!p_known) begin
            err_in = ERR_UNKNOWN;
         end else if (cur_ff.op == OP_SEND) begin
            if (sent_p == ALL_ONES) begin
               err_in = ERR_SEND_OVF;
            end else begin
               do_send      = 1'b1;
               one2_vld_in  = 1'b1;
               one2_in.kind = KIND_TX_DATA;
               one2_in.seq  = sent_p + WORD_W'(1);
            end
         end else if (cur_ff.op == OP_RECV) begin
            if ((cur_ff.epoch != '0) || (recv_p == ALL_ONES) ||
                (cur_ff.seq != recv_p + WORD_W'(1))) begin
               err_in = ERR_NON_FIFO;
            end else if (active_ff && !marked_ff[cur_ff.peer]) begin
               if (rec_bad) begin
                  err_in = ERR_REC_LIMIT;
               end else begin
                  one1_vld_in = 1'b1;
                  one2_vld_in = 1'b1;
                  do_deliver  = 1'b1;
                  recorded_in = recorded_ff + need[SIZE_W-1:0];
               end
            end else begin
               one2_vld_in = 1'b1;
               do_deliver  = 1'b1;
            end
         end else begin
            // marker
            if ((cur_ff.len != '0) || (cur_ff.epoch == '0)) begin
               err_in = ERR_BAD_MARKER;
            end else if (cur_ff.seq != recv_p) begin
               err_in = ERR_FRONTIER;
            end else if (!active_ff) begin
               err_in = st_err;
               if (st_err == ERR_OK) begin
                  do_start    = 1'b1;
                  do_mark     = 1'b1;
                  loop_vld_in = 1'b1;
                  marked_new  = p_bit;
               end
            end else if ((cur_epoch_ff != cur_ff.epoch) || marked_ff[cur_ff.peer]) begin
               err_in = ERR_DUP_MARKER;
            end else begin
               do_mark = 1'b1;
            end
            if (do_mark) begin
               marked_in = marked_new;
               if (&(marked_new | ~in_use)) begin
                  done_in      = 1'b1;
                  fin_epoch_in = cur_ff.epoch;
               end
            end
         end

         if (do_start) begin
            cur_epoch_in = cur_ff.epoch;
            recorded_in  = cur_ff.cap;
            if (!do_mark) marked_in = '0;
         end
         active_in = do_start | active_ff;
         if (done_in && !done_ff) active_in = 1'b0;
         if (err_in != ERR_OK && err_in != ERR_FAILED && err_in != ERR_INCOMPLETE) begin
            failed_in = 1'b1;
         end
      end
   end

   // result sequencing
   assign li = idx_ff[PEER_W-1:0];

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      q_pop     = 1'b0;
      rsp_write = 1'b0;
      rsp_item  = '0;
      rsp_item.kind = KIND_STATUS;
      rsp_item.err  = ERR_OK;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            idx_in = '0;
            priority if (loop_vld_in && n_use != '0) state_in = BK_LOOP;
            else if (one1_vld_in)                   state_in = BK_ONE1;
            else if (one2_vld_in)                   state_in = BK_ONE2;
            else                                    state_in = BK_STATUS;
         end
         BK_LOOP: begin
            rsp_item.peer = li;
            rsp_item.seq  = snap_sent_ff[li];
            if (loop_entry_ff) begin
               rsp_item.kind = KIND_ENTRY;
               rsp_item.rcv  = snap_recv_ff[li];
               rsp_item.mseq = mseq_ff[li];
            end else begin
               rsp_item.kind  = KIND_TX_MARKER;
               rsp_item.epoch = cur_epoch_ff;
            end
            rsp_write = 1'b1;
            if (!rsp_full) begin
               idx_in = idx_ff + NUM_W'(1);
               if (idx_ff + NUM_W'(1) == n_use) state_in = BK_STATUS;
            end
         end
         BK_ONE1: begin
            rsp_item  = one1_ff;
            rsp_write = 1'b1;
            if (!rsp_full) state_in = BK_ONE2;
         end
         BK_ONE2: begin
            rsp_item  = one2_ff;
            rsp_write = 1'b1;
            if (!rsp_full) state_in = BK_STATUS;
         end
         BK_STATUS: begin
            rsp_item.epoch     = fin_epoch_ff;
            rsp_item.completed = done_ff;
            rsp_item.err       = err_ff;
            rsp_item.last      = 1'b1;
            rsp_write = 1'b1;
            if (!rsp_full) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         marked_ff    <= '0;
         active_ff    <= 1'b0;
         done_ff      <= 1'b0;
         cur_epoch_ff <= '0;
         fin_epoch_ff <= '0;
         recorded_ff  <= '0;
         failed_ff    <= 1'b0;
         for (int i = 0; i < MAX_PEERS; i++) begin
            sent_ff[i] <= '0;
            recv_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         marked_ff    <= marked_in;
         active_ff    <= active_in;
         done_ff      <= done_in;
         cur_epoch_ff <= cur_epoch_in;
         fin_epoch_ff <= fin_epoch_in;
         recorded_ff  <= recorded_in;
         failed_ff    <= failed_in;
         if (do_send)    sent_ff[cur_ff.peer] <= sent_p + WORD_W'(1);
         if (do_deliver) recv_ff[cur_ff.peer] <= cur_ff.seq;
      end
   end

   // payload registers and snapshot copies
   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_item;
      idx_ff <= idx_in;
      if (exec) begin
         err_ff        <= err_in;
         loop_entry_ff <= loop_entry_in;
         one1_ff       <= one1_in;
         one2_ff       <= one2_in;
      end
      if (do_start) begin
         // a marker that starts the snapshot records its own sequence at once
         for (int i = 0; i < MAX_PEERS; i++) begin
            snap_sent_ff[i] <= sent_ff[i];
            snap_recv_ff[i] <= recv_ff[i];
            mseq_ff[i]      <= (do_mark && (PEER_W'(i) == cur_ff.peer)) ? cur_ff.seq : '0;
         end
      end else if (do_mark) begin
         mseq_ff[cur_ff.peer] <= cur_ff.seq;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/snapshot_marker_participant_unit.sv =====
// top level of the snapshot marker participant
// usage:
//  - request channel: drive req_* fields with push; a request is taken on a
//    clock edge with push high and full low; two requests can wait in front
//  - result channel: while empty is low the oldest result is on rsp_*; pop
//    takes it; every request ends with a status result carrying rsp_last
//  - csr channel: csr_index 0 peer count, 1 record limit; csr_ready is
//    always high; write only while no request is in flight
//  - timing: one request at a time in the back end; it passes idle and
//    exec, then, if no error, the marker or entry loop for initiate, a
//    starting marker or take (one result per cycle into the result queue
//    while it is not full) or a data event's one or two results, and
//    last the status result
//  - reset: synchronous, active high; counters, flags and epochs clear,
//    peer count goes to 0 and record limit to 65536; queues empty
//  - stall: when pop stays low the 4-entry result queue fills, the back
//    end holds, then the 2-entry request queue fills and full rises
`timescale 1ns / 1ps
`default_nettype none
module snapshot_marker_participant_unit
   import smp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               push,
   output logic                    full,
   input  wire logic [2:0]         req_type,
   input  wire logic [PEER_W-1:0]  req_peer,
   input  wire logic [WORD_W-1:0]  req_epoch,
   input  wire logic [WORD_W-1:0]  req_sequence_req,
   input  wire logic [LEN_W-1:0]   req_payload_length,
   input  wire logic [SIZE_W-1:0]  req_captured_size,
   // result channel
   output logic                    empty,
   input  wire logic               pop,
   output logic [2:0]              rsp_out_kind,
   output logic [PEER_W-1:0]       rsp_out_peer,
   output logic [WORD_W-1:0]       rsp_out_sequence,
   output logic [WORD_W-1:0]       rsp_out_received,
   output logic [WORD_W-1:0]       rsp_out_marker_sequence,
   output logic [WORD_W-1:0]       rsp_out_epoch,
   output logic [LEN_W-1:0]        rsp_out_length,
   output logic                    rsp_completed,
   output logic [3:0]              rsp_error_code,
   output logic                    rsp_last,
   // csr write channel
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [SIZE_W-1:0]  csr_data
);

   cfg_type      cfg_ff;
   logic         q_valid, q_pop;
   req_item_type q_item;
   logic         rsp_write, rsp_full;
   rsp_item_type rsp_wr_item, rsp_rd_item;

   // csr registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.peer_count   <= '0;
         cfg_ff.record_limit <= SIZE_W'(65536);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PEER_COUNT:   cfg_ff.peer_count   <= csr_data[NUM_W-1:0];
            CSR_RECORD_LIMIT: cfg_ff.record_limit <= csr_data;
            default: ;
         endcase
      end
   end

   // front: request queue and decode
   smp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_type           (req_type),
      .req_peer           (req_peer),
      .req_epoch          (req_epoch),
      .req_sequence_req   (req_sequence_req),
      .req_payload_length (req_payload_length),
      .req_captured_size  (req_captured_size),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   // back: state and execution
   smp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .cfg       (cfg_ff),
      .rsp_write (rsp_write),
      .rsp_item  (rsp_wr_item),
      .rsp_full  (rsp_full)
   );

   // result queue decouples the receiver
   smp_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_write),
      .wr_item (rsp_wr_item),
      .wr_full (rsp_full),
      .pop     (pop),
      .empty   (empty),
      .rd_item (rsp_rd_item)
   );

   assign rsp_out_kind            = rsp_rd_item.kind;
   assign rsp_out_peer            = rsp_rd_item.peer;
   assign rsp_out_sequence        = rsp_rd_item.seq;
   assign rsp_out_received        = rsp_rd_item.rcv;
   assign rsp_out_marker_sequence = rsp_rd_item.mseq;
   assign rsp_out_epoch           = rsp_rd_item.epoch;
   assign rsp_out_length          = rsp_rd_item.len;
   assign rsp_completed           = rsp_rd_item.completed;
   assign rsp_error_code          = rsp_rd_item.err;
   assign rsp_last                = rsp_rd_item.last;

endmodule
`default_nettype wire

// ===== sim/smp_checker.sv =====
// checker: predicts participant results and compares them at the result port
`timescale 1ns / 1ps
`default_nettype none
module smp_checker
   import smp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire logic               full,
   input  wire logic [2:0]         req_type,
   input  wire logic [PEER_W-1:0]  req_peer,
   input  wire logic [WORD_W-1:0]  req_epoch,
   input  wire logic [WORD_W-1:0]  req_sequence_req,
   input  wire logic [LEN_W-1:0]   req_payload_length,
   input  wire logic [SIZE_W-1:0]  req_captured_size,
   input  wire logic               empty,
   input  wire logic               pop,
   input  wire logic [2:0]         rsp_out_kind,
   input  wire logic [PEER_W-1:0]  rsp_out_peer,
   input  wire logic [WORD_W-1:0]  rsp_out_sequence,
   input  wire logic [WORD_W-1:0]  rsp_out_received,
   input  wire logic [WORD_W-1:0]  rsp_out_marker_sequence,
   input  wire logic [WORD_W-1:0]  rsp_out_epoch,
   input  wire logic [LEN_W-1:0]   rsp_out_length,
   input  wire logic               rsp_completed,
   input  wire logic [3:0]         rsp_error_code,
   input  wire logic               rsp_last,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [SIZE_W-1:0]  csr_data,
   output int                      fail_count,
   output int                      pending
);

   logic [WORD_W-1:0] sent_q [MAX_PEERS];
   logic [WORD_W-1:0] rcvd_q [MAX_PEERS];
   logic [WORD_W-1:0] snap_sent [MAX_PEERS];
   logic [WORD_W-1:0] snap_rcvd [MAX_PEERS];
   logic [WORD_W-1:0] mark_seq [MAX_PEERS];
   logic [MAX_PEERS-1:0] marked;
   logic active, done, failed;
   logic [WORD_W-1:0] cur_epoch, fin_epoch;
   logic [WORD_W-1:0] rec_bytes;
   logic [NUM_W-1:0] n_peers;
   logic [SIZE_W-1:0] rec_limit;
   rsp_item_type expected_rsps [$];

   assign pending = expected_rsps.size();

   function automatic int peers_used();
      return (n_peers > MAX_PEERS) ? MAX_PEERS : int'(n_peers);
   endfunction

   task automatic push_rsp(kind_type k, int p, logic [WORD_W-1:0] s,
                           logic [WORD_W-1:0] r, logic [WORD_W-1:0] m,
                           logic [WORD_W-1:0] e, logic [LEN_W-1:0] l,
                           logic c, err_type er, logic la);
      rsp_item_type x;
      x.kind = k; x.peer = p[PEER_W-1:0]; x.seq = s; x.rcv = r; x.mseq = m;
      x.epoch = e; x.len = l; x.completed = c; x.err = er; x.last = la;
      expected_rsps.insert(expected_rsps.size(), x);
   endtask

   task automatic begin_snapshot(logic [WORD_W-1:0] ep, logic [SIZE_W-1:0] cap,
                                 output err_type er);
      er = ERR_OK;
      if (!(ep > fin_epoch) || active || done) er = ERR_STALE;
      else if (cap > rec_limit) er = ERR_STATE_LIMIT;
      else begin
         for (int i = 0; i < MAX_PEERS; i++) begin
            snap_sent[i] = sent_q[i];
            snap_rcvd[i] = rcvd_q[i];
            mark_seq[i] = '0;
         end
         cur_epoch = ep;
         rec_bytes = cap;
         active = 1'b1;
         marked = '0;
         for (int i = 0; i < peers_used(); i++)
            push_rsp(KIND_TX_MARKER, i, sent_q[i], 0, 0, ep, 0, 0, ERR_OK, 0);
      end
   endtask

   task automatic close_if_ready();
      int c;
      c = 0;
      for (int i = 0; i < peers_used(); i++) if (marked[i]) c++;
      if (active && c == peers_used()) begin
         fin_epoch = cur_epoch;
         done = 1'b1;
         active = 1'b0;
      end
   endtask

   // predict the results of one accepted request
   task automatic predict_request(logic [2:0] op, logic [PEER_W-1:0] p,
                                  logic [WORD_W-1:0] ep, logic [WORD_W-1:0] sq,
                                  logic [LEN_W-1:0] len, logic [SIZE_W-1:0] cap);
      err_type er;
      logic sets_fail;
      logic [WORD_W-1:0] avail;
      er = ERR_OK;
      sets_fail = 1'b1;
      if (op > OP_TAKE) begin
      end else if (failed) begin
         er = ERR_FAILED; sets_fail = 1'b0;
      end else if (op == OP_INIT) begin
         begin_snapshot(ep, cap, er);
         if (er == ERR_OK) close_if_ready();
      end else if (op == OP_TAKE) begin
         sets_fail = 1'b0;
         if (!done) er = ERR_INCOMPLETE;
         else begin
            for (int i = 0; i < peers_used(); i++)
               push_rsp(KIND_ENTRY, i, snap_sent[i], snap_rcvd[i], mark_seq[i],
                        0, 0, 0, ERR_OK, 0);
            done = 1'b0;
         end
      end else if (int'(p) >= peers_used()) begin
         er = ERR_UNKNOWN;
      end else if (op == OP_SEND) begin
         if (sent_q[p] == '1) er = ERR_SEND_OVF;
         else begin
            sent_q[p] = sent_q[p] + 1;
            push_rsp(KIND_TX_DATA, p, sent_q[p], 0, 0, 0, len, 0, ERR_OK, 0);
         end
      end else if (op == OP_RECV) begin
         if (ep != 0 || rcvd_q[p] == '1 || sq != rcvd_q[p] + 1) er = ERR_NON_FIFO;
         else begin
            if (active && !marked[p]) begin
               if (rec_bytes > rec_limit) er = ERR_REC_LIMIT;
               else begin
                  avail = rec_limit - rec_bytes;
                  if (RECORD_OVERHEAD > avail || len > avail - RECORD_OVERHEAD)
                     er = ERR_REC_LIMIT;
               end
               if (er == ERR_OK) begin
                  push_rsp(KIND_RECORD, p, sq, 0, 0, 0, len, 0, ERR_OK, 0);
                  rec_bytes = rec_bytes + RECORD_OVERHEAD + len;
               end
            end
            if (er == ERR_OK) begin
               rcvd_q[p] = sq;
               push_rsp(KIND_DELIVER, p, sq, 0, 0, 0, len, 0, ERR_OK, 0);
            end
         end
      end else begin
         if (len != 0 || ep == 0) er = ERR_BAD_MARKER;
         else if (sq != rcvd_q[p]) er = ERR_FRONTIER;
         else begin
            if (!active) begin_snapshot(ep, cap, er);
            if (er == ERR_OK) begin
               if (cur_epoch != ep || marked[p]) er = ERR_DUP_MARKER;
               else begin
                  marked[p] = 1'b1;
                  mark_seq[p] = sq;
                  close_if_ready();
               end
            end
         end
      end
      if (er != ERR_OK && sets_fail) failed = 1'b1;
      push_rsp(KIND_STATUS, 0, 0, 0, 0, fin_epoch, 0, done, er, 1);
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         for (int i = 0; i < MAX_PEERS; i++) begin
            sent_q[i] = '0; rcvd_q[i] = '0;
            snap_sent[i] = '0; snap_rcvd[i] = '0; mark_seq[i] = '0;
         end
         marked = '0; active = 0; done = 0; failed = 0;
         cur_epoch = '0; fin_epoch = '0; rec_bytes = '0;
         n_peers = '0; rec_limit = 24'd65536;
         expected_rsps.delete();
         fail_count = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result kind %0d", rsp_out_kind);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_out_kind !== want.kind || rsp_out_peer !== want.peer ||
                   rsp_out_sequence !== want.seq || rsp_out_received !== want.rcv ||
                   rsp_out_marker_sequence !== want.mseq ||
                   rsp_out_epoch !== want.epoch || rsp_out_length !== want.len ||
                   rsp_completed !== want.completed ||
                   rsp_error_code !== want.err || rsp_last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch exp k%0d p%0d s%h r%h m%h e%h l%0d c%0d er%0d la%0d",
                        want.kind, want.peer, want.seq, want.rcv, want.mseq,
                        want.epoch, want.len, want.completed, want.err, want.last,
                        " / got k%0d p%0d s%h r%h m%h e%h l%0d c%0d er%0d la%0d",
                        rsp_out_kind, rsp_out_peer, rsp_out_sequence,
                        rsp_out_received, rsp_out_marker_sequence, rsp_out_epoch,
                        rsp_out_length, rsp_completed, rsp_error_code, rsp_last);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PEER_COUNT) n_peers = csr_data[NUM_W-1:0];
            else if (csr_index == CSR_RECORD_LIMIT) rec_limit = csr_data;
         end
         if (push && !full)
            predict_request(req_type, req_peer, req_epoch, req_sequence_req,
                            req_payload_length, req_captured_size);
      end
   end

endmodule
`default_nettype wire

// ===== sim/tb_snapshot_marker_participant_unit.sv =====
// testbench top: stimulus for the snapshot marker participant and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_snapshot_marker_participant_unit;
   import smp_pkg::*;

   logic clock = 0, reset = 1;
   logic push = 0, pop = 0, csr_valid = 0;
   logic full, empty, csr_ready;
   logic [2:0] req_type = '0;
   logic [PEER_W-1:0] req_peer = '0;
   logic [WORD_W-1:0] req_epoch = '0, req_sequence_req = '0;
   logic [LEN_W-1:0] req_payload_length = '0;
   logic [SIZE_W-1:0] req_captured_size = '0;
   logic [1:0] csr_index = '0;
   logic [SIZE_W-1:0] csr_data = '0;
   logic [2:0] rsp_out_kind;
   logic [PEER_W-1:0] rsp_out_peer;
   logic [WORD_W-1:0] rsp_out_sequence, rsp_out_received;
   logic [WORD_W-1:0] rsp_out_marker_sequence, rsp_out_epoch;
   logic [LEN_W-1:0] rsp_out_length;
   logic rsp_completed, rsp_last;
   logic [3:0] rsp_error_code;
   int fail_count, pending;
   int cycle_count = 0;
   logic calm = 0;          // no idling on either side while set

   // tb-side mirror of the counters, used only to build well-formed traffic
   logic [WORD_W-1:0] next_rx [MAX_PEERS];
   logic [WORD_W-1:0] epoch_gen = 0;
   int n_used = 0;

   always #1 clock = ~clock;

   snapshot_marker_participant_unit u_dut (.*);
   smp_checker u_chk (.*);

   // result side: pop with random stalls
   always @(posedge clock) begin
      if (reset) pop <= 0;
      else pop <= calm ? 1'b1 : ($urandom_range(99) >= 20);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // send one request, waiting out full; random idle before it
   task automatic send_req(logic [2:0] op, logic [PEER_W-1:0] p,
                           logic [WORD_W-1:0] ep, logic [WORD_W-1:0] sq,
                           logic [LEN_W-1:0] len, logic [SIZE_W-1:0] cap);
      while (!calm && $urandom_range(99) < 20) begin
         push <= 0;
         @(posedge clock);
      end
      push <= 1; req_type <= op; req_peer <= p; req_epoch <= ep;
      req_sequence_req <= sq; req_payload_length <= len; req_captured_size <= cap;
      @(posedge clock);
      while (full) @(posedge clock);
      if (op == OP_RECV && ep == 0 && sq == next_rx[p] + 1) next_rx[p] = sq;
   endtask

   task automatic drain();
      push <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // register write only with the block idle
   task automatic write_csr(logic [1:0] idx, logic [SIZE_W-1:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // new peer count and record limit after a drain: no reset, so recover only while not failed
   task automatic new_setting(int peers, logic [SIZE_W-1:0] lim);
      drain();
      write_csr(CSR_PEER_COUNT, SIZE_W'(peers));
      write_csr(CSR_RECORD_LIMIT, lim);
      n_used = (peers > MAX_PEERS) ? MAX_PEERS : peers;
   endtask

   // well-formed snapshot round with random data interleaved
   task automatic snapshot_round(bit by_marker);
      int order [$];
      int p;
      epoch_gen = epoch_gen + $urandom_range(1, 3);
      for (int i = 0; i < n_used; i++) order.insert(order.size(), i);
      order.shuffle();
      if (!by_marker || n_used == 0)
         send_req(OP_INIT, 0, epoch_gen, 0, 0, SIZE_W'($urandom_range(200)));
      for (int i = 0; i < order.size(); i++) begin
         repeat ($urandom_range(2)) begin
            p = $urandom_range(n_used - 1);
            if ($urandom_range(1))
               send_req(OP_SEND, PEER_W'(p), 0, 0, LEN_W'($urandom), 0);
            else
               send_req(OP_RECV, PEER_W'(p), 0, next_rx[p] + 1,
                        LEN_W'($urandom_range(300)), 0);
         end
         send_req(OP_MARK, PEER_W'(order[i]), epoch_gen, next_rx[order[i]], 0,
                  SIZE_W'($urandom_range(200)));
      end
      send_req(OP_TAKE, 0, 0, 0, 0, 0);
   endtask

   initial begin
      int p;
      for (int i = 0; i < MAX_PEERS; i++) next_rx[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero peers, take with nothing held, unused code
      send_req(OP_TAKE, 0, 0, 0, 0, 0);
      send_req(3'd7, 4'hF, '1, '1, '1, '1);
      send_req(OP_NONE, 0, 0, 0, 0, 0);
      epoch_gen = 1;
      send_req(OP_INIT, 0, 1, 0, 0, 0);
      send_req(OP_TAKE, 0, 0, 0, 0, 0);

      // clean snapshot rounds before anything can trip the failure flag
      new_setting(4, 24'hFFFFFF);
      snapshot_round(1);
      snapshot_round(0);

      // random traffic; the first error makes the node answer failed from then on
      new_setting(16, 24'hFFFFFF);
      for (int k = 0; k < 6; k++)
         send_req(k[2:0], PEER_W'($urandom), WORD_W'($urandom), WORD_W'($urandom),
                  LEN_W'($urandom), SIZE_W'($urandom));
      new_setting(31, 1);
      for (int k = 0; k < 6; k++)
         send_req(3'($urandom_range(7)), PEER_W'($urandom),
                  {$urandom, $urandom}, {$urandom, $urandom},
                  LEN_W'($urandom), SIZE_W'($urandom));
      new_setting(0, 65536);

      // sender pause until everything returned
      drain();
      calm = 1;
      for (int k = 0; k < 20; k++)
         send_req(3'($urandom_range(7)), PEER_W'($urandom), 0, 0, 0, 0);
      calm = 0;
      for (int k = 0; k < 50; k++) begin
         p = $urandom_range(15);
         send_req(3'($urandom_range(7)), PEER_W'(p), {$urandom, $urandom},
                  {$urandom, $urandom}, LEN_W'($urandom), SIZE_W'($urandom));
      end
      snapshot_round(0);
      send_req(OP_SEND, 4'hF, 0, 0, 0, 0);          // unknown peer, fails node
      send_req(OP_RECV, 0, 0, 1, 0, 0);             // failed node answers
      drain();

      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire
